// File: design/bafs_pkg.sv
// ----------------------------------------------------------------------------
// bafs_pkg: shared constants, types and helpers for the bit-addressed store
// Store geometry, derived widths, operation codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bafs_pkg;

	// store geometry
	localparam int STORE_WORDS = 1024;
	localparam int WORD_BITS   = 16;
	localparam int CAP_BITS    = STORE_WORDS * WORD_BITS;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int ADDR_W  = 15;
	localparam int DATA_W  = 16;
	localparam int COUNT_W = 5;
	localparam int STEP_W  = 15;

	localparam int IN_BITS   = OP_W + ADDR_W + DATA_W + COUNT_W + STEP_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = DATA_W + ADDR_W + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// pointer holds 0..CAP_BITS; arithmetic wide enough for pointer + step
	localparam int CAP_W   = $clog2(CAP_BITS + 1);
	localparam int PTR_W   = CAP_W;
	localparam int ARITH_W = ((CAP_W > ADDR_W) ? CAP_W : ADDR_W) + 1;

	// even/odd word banks, so two adjacent words are read together
	localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE    = 3'd0,
		OP_READ     = 3'd1,
		OP_APPEND   = 3'd2,
		OP_READ_PTR = 3'd3,
		OP_SET_PTR  = 3'd4,
		OP_ADVANCE  = 3'd5,
		OP_RETREAT  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clear;   // zero one row of both banks
		logic load;    // capture the input beat
		logic calc;    // register start, length and range flag
		logic commit;  // write back, update pointer, load result
	} cmd_t;

	typedef struct packed {
		logic clear_last; // clear counter on the last row
	} status_t;

	// low n bits set, n already limited to 0..16
	function automatic logic [DATA_W-1:0] field_mask(input logic [COUNT_W-1:0] n);
		logic [DATA_W:0] one_hot;
		one_hot = (DATA_W + 1)'(1) << n;
		return (n >= COUNT_W'(WORD_BITS)) ? {DATA_W{1'b1}} : DATA_W'(one_hot - 1'b1);
	endfunction

endpackage

// File: design/bafs_ram.sv
// ----------------------------------------------------------------------------
// bafs_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bafs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/bafs_dp.sv
// ----------------------------------------------------------------------------
// bafs_dp: datapath of the bit-addressed store
// Item registers, bit pointer, even/odd word banks, field merge and extract,
// result register.
// ----------------------------------------------------------------------------
module bafs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bafs_pkg::cmd_t                  cmd,
	output bafs_pkg::status_t               status,
	input  logic [bafs_pkg::OP_W-1:0]       operation,
	input  logic [bafs_pkg::ADDR_W-1:0]     bit_address,
	input  logic [bafs_pkg::DATA_W-1:0]     field_data,
	input  logic [bafs_pkg::COUNT_W-1:0]    bit_count,
	input  logic [bafs_pkg::STEP_W-1:0]     pointer_step,
	output logic [bafs_pkg::DATA_W-1:0]     read_value,
	output logic [bafs_pkg::ADDR_W-1:0]     pointer_now,
	output logic                            out_of_range
);

	localparam int AW = bafs_pkg::ARITH_W;
	localparam int BW = bafs_pkg::BANK_AW;
	localparam int DW = bafs_pkg::DATA_W;

	// item registers
	bafs_pkg::op_t                   op_q;
	logic [bafs_pkg::ADDR_W-1:0]     addr_q;
	logic [DW-1:0]                   data_q;
	logic [bafs_pkg::COUNT_W-1:0]    cnt_q;
	logic [bafs_pkg::STEP_W-1:0]     step_q;

	logic [bafs_pkg::PTR_W-1:0]      ptr_q;
	logic [BW-1:0]                   clr_q;

	// access geometry, registered in the read cycle
	logic [AW-1:0]                   start_q;
	logic [bafs_pkg::COUNT_W-1:0]    n_q;
	logic                            oor_q;

	// result register
	logic [DW-1:0]                   rv_q;
	logic [bafs_pkg::ADDR_W-1:0]     ptr_out_q;
	logic                            oor_out_q;

	logic                            is_addr_op;
	logic                            is_access;
	logic [AW-1:0]                   start_c;
	logic [bafs_pkg::COUNT_W-1:0]    n_c;
	logic [AW-1:0]                   end_c;
	logic [AW-1:0]                   cap_c;
	logic [AW-1:0]                   row_c;
	logic [BW-1:0]                   idx_c;
	logic [BW-1:0]                   even_raddr;

	logic [AW-1:0]                   row_w;
	logic [BW-1:0]                   idx_w;
	logic                            w_odd;
	logic [3:0]                      off_w;
	logic [DW-1:0]                   even_rdata;
	logic [DW-1:0]                   odd_rdata;
	logic [2*DW-1:0]                 win;
	logic [2*DW-1:0]                 mask_w;
	logic [2*DW-1:0]                 ins_w;
	logic [2*DW-1:0]                 new_win;
	logic [2*DW-1:0]                 win_sh;
	logic [DW-1:0]                   fmask;
	logic [DW-1:0]                   field_c;
	logic                            lo_need;
	logic                            hi_need;
	logic                            wr_ok;
	logic                            is_rd_op;

	logic                            even_we;
	logic [BW-1:0]                   even_waddr;
	logic [DW-1:0]                   even_wdata;
	logic                            odd_we;
	logic [BW-1:0]                   odd_waddr;
	logic [DW-1:0]                   odd_wdata;

	logic [AW-1:0]                   ptr_ext;
	logic [AW-1:0]                   addr_ext;
	logic [AW-1:0]                   step_ext;
	logic [AW-1:0]                   adv_sum;
	logic [AW-1:0]                   ptr_n;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= bafs_pkg::op_t'(operation);
			addr_q <= bit_address;
			data_q <= field_data;
			cnt_q  <= bit_count;
			step_q <= pointer_step;
		end
	end

	// start, length, range check
	always_comb begin
		is_addr_op = (op_q == bafs_pkg::OP_WRITE) || (op_q == bafs_pkg::OP_READ);
		is_access  = is_addr_op || (op_q == bafs_pkg::OP_APPEND) ||
		             (op_q == bafs_pkg::OP_READ_PTR);
		start_c    = is_addr_op ? AW'(addr_q) : AW'(ptr_q);
		n_c        = (cnt_q > bafs_pkg::COUNT_W'(bafs_pkg::WORD_BITS)) ?
		             bafs_pkg::COUNT_W'(bafs_pkg::WORD_BITS) : cnt_q;
		end_c      = start_c + AW'(n_c);
		cap_c      = AW'(bafs_pkg::CAP_BITS);
		row_c      = start_c >> 5;
		idx_c      = row_c[BW-1:0];
		even_raddr = start_c[4] ? (idx_c + BW'(1)) : idx_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			start_q <= start_c;
			n_q     <= n_c;
			oor_q   <= is_access && (end_c > cap_c);
		end
	end

	// word banks: word w sits in bank w[0] at row w >> 1
	bafs_ram #(
		.WIDTH (DW),
		.DEPTH (bafs_pkg::BANK_DEPTH)
	) u_even_ram (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_waddr),
		.wdata (even_wdata),
		.raddr (even_raddr),
		.rdata (even_rdata)
	);

	bafs_ram #(
		.WIDTH (DW),
		.DEPTH (bafs_pkg::BANK_DEPTH)
	) u_odd_ram (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_waddr),
		.wdata (odd_wdata),
		.raddr (idx_c),
		.rdata (odd_rdata)
	);

	// merge and extract over the two-word window
	always_comb begin
		row_w    = start_q >> 5;
		idx_w    = row_w[BW-1:0];
		w_odd    = start_q[4];
		off_w    = start_q[3:0];
		win      = w_odd ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
		fmask    = bafs_pkg::field_mask(n_q);
		mask_w   = {{DW{1'b0}}, fmask} << off_w;
		ins_w    = {{DW{1'b0}}, data_q} << off_w;
		new_win  = (win & ~mask_w) | (ins_w & mask_w);
		win_sh   = win >> off_w;
		field_c  = win_sh[DW-1:0] & fmask;
		lo_need  = (n_q != '0);
		hi_need  = |mask_w[2*DW-1:DW];
		is_rd_op = (op_q == bafs_pkg::OP_READ) || (op_q == bafs_pkg::OP_READ_PTR);
		wr_ok    = cmd.commit && !oor_q &&
		           ((op_q == bafs_pkg::OP_WRITE) || (op_q == bafs_pkg::OP_APPEND));

		even_we    = cmd.clear || (wr_ok && (w_odd ? hi_need : lo_need));
		odd_we     = cmd.clear || (wr_ok && (w_odd ? lo_need : hi_need));
		even_waddr = cmd.clear ? clr_q : (w_odd ? (idx_w + BW'(1)) : idx_w);
		odd_waddr  = cmd.clear ? clr_q : idx_w;
		even_wdata = cmd.clear ? '0 : (w_odd ? new_win[2*DW-1:DW] : new_win[DW-1:0]);
		odd_wdata  = cmd.clear ? '0 : (w_odd ? new_win[DW-1:0] : new_win[2*DW-1:DW]);
	end

	// pointer update
	always_comb begin
		ptr_ext  = AW'(ptr_q);
		addr_ext = AW'(addr_q);
		step_ext = AW'(step_q);
		adv_sum  = ptr_ext + step_ext;
		case (op_q)
			bafs_pkg::OP_APPEND: begin
				ptr_n = oor_q ? ptr_ext : (start_q + AW'(n_q));
			end
			bafs_pkg::OP_SET_PTR: begin
				ptr_n = (addr_ext > cap_c) ? cap_c : addr_ext;
			end
			bafs_pkg::OP_ADVANCE: begin
				ptr_n = (adv_sum > cap_c) ? cap_c : adv_sum;
			end
			bafs_pkg::OP_RETREAT: begin
				ptr_n = (step_ext > ptr_ext) ? '0 : (ptr_ext - step_ext);
			end
			default: begin
				ptr_n = ptr_ext;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.commit) begin
				ptr_q <= ptr_n[bafs_pkg::PTR_W-1:0];
			end
			if (cmd.clear) begin
				clr_q <= clr_q + BW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rv_q      <= (is_rd_op && !oor_q) ? field_c : '0;
			ptr_out_q <= ptr_n[bafs_pkg::ADDR_W-1:0];
			oor_out_q <= oor_q;
		end
	end

	assign status.clear_last = (clr_q == BW'(bafs_pkg::BANK_DEPTH - 1));
	assign read_value        = rv_q;
	assign pointer_now       = ptr_out_q;
	assign out_of_range      = oor_out_q;

endmodule

// File: design/bafs_ctrl.sv
// ----------------------------------------------------------------------------
// bafs_ctrl: controller of the bit-addressed store
// Clearing pass after reset, then read / write-back per item; owns both
// handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module bafs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bafs_pkg::status_t status,
	output bafs_pkg::cmd_t    cmd
);

	bafs_pkg::state_t state_q;
	bafs_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bafs_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			bafs_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = bafs_pkg::ST_IDLE;
				end
			end
			bafs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bafs_pkg::ST_READ;
				end
			end
			bafs_pkg::ST_READ: begin
				cmd.calc = 1'b1;
				state_d  = bafs_pkg::ST_WRITE;
			end
			bafs_pkg::ST_WRITE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					in_ready   = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = bafs_pkg::ST_READ;
					end else begin
						state_d  = bafs_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = bafs_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/bit_addressed_field_store_top.sv
// ----------------------------------------------------------------------------
// bit_addressed_field_store_top: bit-addressed store of 16-bit words
// Writes, reads and appends fields of 1 to 16 bits at any bit address or at a
// kept bit pointer, LSB first; fields may span two words. Accesses past
// capacity are flagged and dropped.
//
//   channel   dir   beat width   payload
//   s_axis    in    56 bits      operation, bit_address, field_data,
//                                bit_count, pointer_step
//   m_axis    out   32 bits      read_value, pointer_now, out_of_range
//
// Every item passes a read cycle, which reads both adjacent words from the even
// and odd word banks in parallel, and a write-back cycle, which merges and
// writes them back. A new beat is taken in the write-back cycle, so the next
// item starts while the result register drains.
// After reset both banks are zeroed with s_axis_tready low, one row a cycle across
// BANK_DEPTH (512) rows. A stalled m_axis holds the item unwritten in write-back.
// ----------------------------------------------------------------------------
module bit_addressed_field_store_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// [2:0] operation, [17:3] bit_address, [33:18] field_data,
	// [38:34] bit_count, [53:39] pointer_step, [55:54] zero
	input  logic [bafs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] read_value, [30:16] pointer_now, [31] out_of_range
	output logic [bafs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready
);

	localparam int A_LO = bafs_pkg::OP_W;
	localparam int D_LO = A_LO + bafs_pkg::ADDR_W;
	localparam int C_LO = D_LO + bafs_pkg::DATA_W;
	localparam int S_LO = C_LO + bafs_pkg::COUNT_W;

	bafs_pkg::cmd_t                  cmd;
	bafs_pkg::status_t               status;
	logic [bafs_pkg::DATA_W-1:0]     read_value;
	logic [bafs_pkg::ADDR_W-1:0]     pointer_now;
	logic                            out_of_range;

	// sequencing: clear pass, read cycle, write-back cycle
	bafs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// store, pointer and result register
	bafs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (s_axis_tdata[A_LO-1:0]),
		.bit_address  (s_axis_tdata[D_LO-1:A_LO]),
		.field_data   (s_axis_tdata[C_LO-1:D_LO]),
		.bit_count    (s_axis_tdata[S_LO-1:C_LO]),
		.pointer_step (s_axis_tdata[S_LO+bafs_pkg::STEP_W-1:S_LO]),
		.read_value   (read_value),
		.pointer_now  (pointer_now),
		.out_of_range (out_of_range)
	);

	assign m_axis_tdata = bafs_pkg::OUT_TDATA_W'({out_of_range, pointer_now, read_value});

	// no beat taken while the banks are being zeroed
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !s_axis_tready)
		else $error("input beat offered ready during clearing pass");

	// write-back only when the result register can take the result
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("commit would overwrite a pending result");

	// every commit presents a result beat next cycle
	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_axis_tvalid)
		else $error("result missing after commit");

	// a dropped access never returns field bits
	a_oor_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_of_range) |-> (read_value == '0))
		else $error("out-of-range result carries read data");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bit-addressed field store
// Drives access beats on s_axis with bursty flow control and checks every
// m_axis beat against an in-bench model of the word store and bit pointer.
// The directed part covers field extremes, spans, capacity edges and pointer
// saturation; the random part follows with reads aimed at written regions.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bafs_pkg::*;

	// op code 7 has no meaning; the block must answer it with a plain status
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	localparam int RANDOM_ITEMS  = 1825;
	localparam int DRAIN_EVERY   = 450;   // sender waits for an empty pipe here
	localparam int HOLD_AT       = 700;   // long output stall after this many beats
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 3000;  // covers the clearing pass and the stall
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [ADDR_W-1:0]  addr;
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
		logic [STEP_W-1:0]  step;
		bit                 drain;  // hold this beat until every result is back
	} access_t;

	typedef struct packed {
		logic              oor;
		logic [ADDR_W-1:0] ptr;
		logic [DATA_W-1:0] value;
	} status_beat_t;

	typedef enum int {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;

	bit_addressed_field_store_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	// model state: word contents and the bit pointer (0..CAP_BITS)
	logic [DATA_W-1:0] store_model [STORE_WORDS];
	int unsigned       ptr_model;

	access_t      access_q [$];   // beats waiting to be offered
	status_beat_t status_q [$];   // predicted output beats, oldest first

	int unsigned accepted_in;
	int unsigned checked_out;
	int unsigned errors;
	int unsigned oor_seen;
	int unsigned op_seen [8];
	bit          in_taken;        // s_axis beat accepted at the last rising edge

	initial begin
		forever #6 clk = ~clk;
	end

	// Apply one access to the model and return the status beat it produces.
	// Field length is saturated at 16; a zero length touches nothing and is
	// flagged only when the start lies beyond capacity.
	function automatic status_beat_t apply_access(access_t a);
		status_beat_t r;
		int unsigned  n, start, w, off;
		logic [31:0]  win, lo, m;
		r = '0;
		n = (a.count > 16) ? 16 : a.count;
		case (a.op)
			OP_WRITE, OP_READ, OP_APPEND, OP_READ_PTR: begin
				start = (a.op == OP_WRITE || a.op == OP_READ) ? a.addr : ptr_model;
				if (start + n > CAP_BITS) begin
					r.oor = 1'b1;
				end else begin
					w   = start >> 4;
					off = start & 15;
					// two-word window; words past the end read as zero
					win[15:0]  = (w < STORE_WORDS) ? store_model[w] : '0;
					win[31:16] = (w + 1 < STORE_WORDS) ? store_model[w + 1] : '0;
					lo = (32'd1 << n) - 32'd1;
					m  = lo << off;
					if (a.op == OP_WRITE || a.op == OP_APPEND) begin
						win = (win & ~m) | ((32'(a.data) << off) & m);
						if (w < STORE_WORDS)
							store_model[w] = win[15:0];
						if (m[31:16] != 0 && w + 1 < STORE_WORDS)
							store_model[w + 1] = win[31:16];
						if (a.op == OP_APPEND)
							ptr_model = start + n;
					end else begin
						r.value = DATA_W'((win >> off) & lo);
					end
				end
			end
			OP_SET_PTR:
				ptr_model = (a.addr > CAP_BITS) ? CAP_BITS : a.addr;
			OP_ADVANCE:
				ptr_model = (ptr_model + a.step > CAP_BITS) ? CAP_BITS : ptr_model + a.step;
			OP_RETREAT:
				ptr_model = (a.step > ptr_model) ? 0 : ptr_model - a.step;
			default: ;
		endcase
		r.ptr = ADDR_W'(ptr_model);
		return r;
	endfunction

	task automatic add_access(input logic [OP_W-1:0] op, input int unsigned addr,
			input int unsigned data, input int unsigned count, input int unsigned step,
			input bit drain = 1'b0);
		access_t a;
		a.op    = op;
		a.addr  = ADDR_W'(addr);
		a.data  = DATA_W'(data);
		a.count = COUNT_W'(count);
		a.step  = STEP_W'(step);
		a.drain = drain;
		access_q.push_back(a);
	endtask

	task automatic log_error(input string what, input status_beat_t want,
			input status_beat_t got);
		errors++;
		if (errors <= 10)
			$display("[%0t] %s: expected value=%h ptr=%0d oor=%b, got value=%h ptr=%0d oor=%b",
				$realtime, what, want.value, want.ptr, want.oor, got.value, got.ptr, got.oor);
	endtask

	// Sampling side: predict on each accepted input beat, check each output beat.
	always @(posedge clk) begin : sample_blk
		status_beat_t got, want;
		in_taken = s_axis_tvalid && s_axis_tready;
		if (in_taken) begin
			op_seen[access_q[0].op]++;
			status_q.push_back(apply_access(access_q[0]));
			access_q.pop_front();
			accepted_in++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[31:0];
			if (status_q.size() == 0) begin
				log_error("output beat with nothing pending", '0, got);
			end else begin
				want = status_q.pop_front();
				checked_out++;
				if (want.oor)
					oor_seen++;
				if (got !== want)
					log_error("status mismatch", want, got);
			end
		end
	end

	// Sender: bursts of random length separated by random gaps. A beat once
	// offered stays up until taken; a beat marked drain waits for an empty pipe.
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				// beat still waiting for tready
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (access_q.size() == 0 ||
					(access_q[0].drain && status_q.size() != 0)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= IN_TDATA_W'({access_q[0].step, access_q[0].count,
					access_q[0].data, access_q[0].addr, access_q[0].op});
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					// about a third of the bursts run straight into the next
					gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
				end
			end
		end
	end

	// Receiver: stall pattern drawn at random from four modes; one long hold-off
	// lets the block back up and drop s_axis_tready.
	rx_mode_t    rx_mode = RX_STEADY;
	int unsigned rx_cycle;
	int unsigned hold_left;
	bit          hold_done;

	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 50 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && accepted_in >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_STEADY: m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
				RX_SPARSE: m_axis_tready <= (rx_cycle % 4 == 0);
				default:   m_axis_tready <= ($urandom_range(0, 99) < 85);
			endcase
		end
	end

	// Watchdog: no beat on either side for too long ends the run.
	int unsigned idle_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("timeout: no beat for %0d cycles, %0d results outstanding",
						idle_cycles, status_q.size());
					$display("FAIL bit_addressed_field_store_top");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned pick, region, addr, count, step;
		logic [OP_W-1:0] op;

		foreach (store_model[i])
			store_model[i] = '0;
		ptr_model = 0;

		// full-word write and read at bit 0, then the last word exactly
		add_access(OP_WRITE, 0, 16'hFFFF, 16, 0);
		add_access(OP_READ, 0, 0, 16, 0);
		add_access(OP_WRITE, CAP_BITS - 16, 16'hA5C3, 16, 0);
		add_access(OP_READ, CAP_BITS - 16, 0, 16, 0);
		// field spanning two words, read back whole and in part
		add_access(OP_WRITE, 88, 16'h1234, 16, 0);
		add_access(OP_READ, 88, 0, 16, 0);
		add_access(OP_READ, 80, 0, 12, 0);
		// past capacity: write, read, top address; zero length at and past the end
		add_access(OP_WRITE, CAP_BITS - 8, 16'h01FF, 9, 0);
		add_access(OP_READ, CAP_BITS - 15, 0, 16, 0);
		add_access(OP_WRITE, 32767, 1, 1, 0);
		add_access(OP_READ, CAP_BITS, 0, 0, 0);
		add_access(OP_READ, CAP_BITS + 1, 0, 0, 0);
		// zero length writes nothing; lengths above 16 saturate
		add_access(OP_WRITE, 5, 16'hFFFF, 0, 0);
		add_access(OP_WRITE, 200, 16'h7FFF, 31, 0);
		add_access(OP_READ, 200, 0, 20, 0);
		// pointer: append, read without moving, zero-length append, saturation
		add_access(OP_SET_PTR, 100, 0, 0, 0);
		add_access(OP_APPEND, 0, 16'h02AB, 10, 0);
		add_access(OP_READ_PTR, 0, 0, 5, 0);
		add_access(OP_APPEND, 0, 16'hFFFF, 0, 0);
		add_access(OP_SET_PTR, 32767, 0, 0, 0);
		add_access(OP_APPEND, 0, 1, 1, 0);
		add_access(OP_ADVANCE, 0, 0, 0, 5);
		add_access(OP_RETREAT, 0, 0, 0, 32767);
		add_access(OP_ADVANCE, 0, 0, 0, 32767);
		add_access(OP_RETREAT, 0, 0, 0, 3);
		add_access(OP_APPEND, 0, 16'h0007, 3, 0);
		add_access(OP_READ, CAP_BITS - 3, 0, 3, 0);
		add_access(OP_UNUSED, 32767, 16'hFFFF, 31, 32767);

		// Random part. Most addresses sit in a small window so reads land on
		// written bits; some sit at the capacity edge, the rest anywhere.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)      op = OP_WRITE;
			else if (pick < 40) op = OP_READ;
			else if (pick < 60) op = OP_APPEND;
			else if (pick < 72) op = OP_READ_PTR;
			else if (pick < 82) op = OP_SET_PTR;
			else if (pick < 89) op = OP_ADVANCE;
			else if (pick < 96) op = OP_RETREAT;
			else                op = OP_UNUSED;
			region = $urandom_range(0, 9);
			if (region < 6)
				addr = $urandom_range(0, 1023);
			else if (region < 8)
				addr = $urandom_range(CAP_BITS - 48, CAP_BITS + 16);
			else
				addr = $urandom_range(0, 32767);
			count = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
			step  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
			add_access(op, addr, $urandom_range(0, 65535), count, step, (i % DRAIN_EVERY == 0));
		end

		// async reset held low from the start, released between edges
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (access_q.size() != 0 || status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d beats: %0d writes, %0d reads, %0d appends, %0d pointer reads, %0d pointer moves, %0d unused codes",
			accepted_in, op_seen[OP_WRITE], op_seen[OP_READ], op_seen[OP_APPEND],
			op_seen[OP_READ_PTR],
			op_seen[OP_SET_PTR] + op_seen[OP_ADVANCE] + op_seen[OP_RETREAT],
			op_seen[OP_UNUSED]);
		$display("%0d results checked, %0d out of range, %0d mismatches, long output stall %s",
			checked_out, oor_seen, errors, hold_done ? "applied" : "not reached");
		if (errors == 0 && status_q.size() == 0) begin
			$display("PASS bit_addressed_field_store_top");
		end else begin
			$display("FAIL bit_addressed_field_store_top");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/bafs_pkg.sv
design/bafs_ram.sv
design/bafs_dp.sv
design/bafs_ctrl.sv
design/bit_addressed_field_store_top.sv
test/tb_top.sv
